// ===== sv/bir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bicubic resampler package
// Shared constants, operation codes and configuration register indexes.
// ---------------------------------------------------------------------------
package bir_pkg;

   localparam int unsigned MaxSourceWidth     = 512;
   localparam int unsigned MaxSourceHeight    = 512;
   localparam int unsigned WeightFractionBits = 16;

   localparam int unsigned PixelBits = 24;
   localparam int unsigned SizeBits  = 10;
   localparam int unsigned StepBits  = 24;
   localparam int unsigned IndexBits = 12;
   localparam int unsigned CsrIdxBits = 2;

   typedef enum logic [0:0] {
      OP_STORE   = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_SOURCE_WIDTH    = 2'd0,
      CSR_SOURCE_HEIGHT   = 2'd1,
      CSR_HORIZONTAL_STEP = 2'd2,
      CSR_VERTICAL_STEP   = 2'd3
   } csr_idx_type;

endpackage
`default_nettype wire

// ===== sv/bir_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module bir_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] addr,
   input  wire  [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== sv/bir_weights.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Cubic weight generator
// Sequential Keys kernel (a = -0.75) for one 16-bit fraction; go starts
// S_SQ, S_CB, S_N0 and S_RND in turn, and done marks the weights ready.
// ---------------------------------------------------------------------------
module bir_weights
   import bir_pkg::*;
#(
   parameter int unsigned WFB = WeightFractionBits
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    go,
   input  wire  [15:0]            frac,
   output logic                   done,
   output logic signed [WFB+1:0]  w0,
   output logic signed [WFB+1:0]  w1,
   output logic signed [WFB+1:0]  w2,
   output logic signed [WFB+1:0]  w3
);

   localparam int unsigned Shift = 50 - WFB;
   localparam logic signed [55:0] Cube = 56'sd4 <<< 48;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SQ   = 6'b000010,
      S_CB   = 6'b000100,
      S_N0   = 6'b001000,
      S_RND  = 6'b010000,
      S_DONE = 6'b100000
   } st_type;

   st_type state_ff, state_in;
   logic signed [17:0] f_ff, q_ff;
   logic signed [35:0] ff2_ff, qq2_ff;
   logic signed [55:0] n0_ff, n1_ff, n2_ff;
   logic signed [WFB+1:0] w0_ff, w1_ff, w2_ff;

   function automatic logic signed [WFB+1:0] rnd(input logic signed [55:0] v);
      logic signed [55:0] t;
      begin
         t = (v + (56'sd1 <<< (Shift - 1))) >>> Shift;
         rnd = t[WFB+1:0];
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (go) state_in = S_SQ;
         S_SQ:    state_in = S_CB;
         S_CB:    state_in = S_N0;
         S_N0:    state_in = S_RND;
         S_RND:   state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            f_ff <= {2'b00, frac};
            q_ff <= 18'sd65536 - {2'b00, frac};
         end
         S_SQ: begin
            ff2_ff <= f_ff * f_ff;
            qq2_ff <= q_ff * q_ff;
         end
         S_CB: begin
            // 5x^3 - 9x^2 + 4 scaled by 2^48
            n1_ff <= 56'(ff2_ff) * 56'(f_ff) * 56'sd5
                     - 56'(ff2_ff) * 56'sd589824 + Cube;
            n2_ff <= 56'(qq2_ff) * 56'(q_ff) * 56'sd5
                     - 56'(qq2_ff) * 56'sd589824 + Cube;
         end
         S_N0: n0_ff <= -(56'(qq2_ff) * 56'(f_ff) * 56'sd3);
         S_RND: begin
            w0_ff <= rnd(n0_ff);
            w1_ff <= rnd(n1_ff);
            w2_ff <= rnd(n2_ff);
         end
         default: ;
      endcase
   end

   assign done = (state_ff == S_DONE);
   assign w0 = w0_ff;
   assign w1 = w1_ff;
   assign w2 = w2_ff;
   assign w3 = (WFB+2)'(1 << WFB) - w0_ff - w1_ff - w2_ff;

endmodule
`default_nettype wire

// ===== sv/bicubic_image_resampler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bicubic image resampler
// Source image store plus bicubic (a = -0.75) destination pixel compute.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with a word on the req_ ports while busy is low. A store
//   word (operation 0) writes one RGB pixel into the source RAM in the
//   accepting cycle if its column and row lie inside the maximum source
//   size; busy stays low, so stores can follow back to back. A compute
//   word (operation 1) maps the destination pixel into the source as it
//   is accepted, builds horizontal and vertical weights, then reads the
//   4x4 window from the single-port source RAM, one pixel per cycle,
//   with an S_ROW step after each window row to close the line, folds
//   the last row in S_FIN and presents the result. The result is on rsp_
//   with done high in S_OUT. busy stays high through S_OUT, so a new
//   word is taken only after the compute has ended. There is no back
//   pressure.
//   Configuration via csr_ is taken at any cycle and should only change
//   while idle. Reset returns the registers to 512x512 with a unit step;
//   the source RAM keeps its contents and is undefined until written.
// ---------------------------------------------------------------------------
module bicubic_image_resampler_top
   import bir_pkg::*;
#(
   parameter int unsigned MAX_SOURCE_WIDTH     = MaxSourceWidth,
   parameter int unsigned MAX_SOURCE_HEIGHT    = MaxSourceHeight,
   parameter int unsigned WEIGHT_FRACTION_BITS = WeightFractionBits
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire                   req_operation,
   input  wire  [IndexBits-1:0]  req_column,
   input  wire  [IndexBits-1:0]  req_row,
   input  wire  [7:0]            req_red_in,
   input  wire  [7:0]            req_green_in,
   input  wire  [7:0]            req_blue_in,
   output logic                  done,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   input  wire                   csr_write,
   input  wire  [CsrIdxBits-1:0] csr_index,
   input  wire  [StepBits-1:0]   csr_data
);

   localparam int unsigned WFB   = WEIGHT_FRACTION_BITS;
   localparam int unsigned XBits = $clog2(MAX_SOURCE_WIDTH);
   localparam int unsigned YBits = $clog2(MAX_SOURCE_HEIGHT);
   localparam int unsigned ABits = XBits + YBits;
   localparam int unsigned Depth = 1 << ABits;
   localparam int unsigned LineBits = WFB + 14;   // 8-bit pixel times weights
   localparam int unsigned AccBits  = 2 * WFB + 16;
   localparam int unsigned Sh = 2 * WFB;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MAP  = 7'b0000010,
      S_WGT  = 7'b0000100,
      S_RD   = 7'b0001000,
      S_ROW  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } st_type;

   // configuration
   logic [SizeBits-1:0] width_ff, height_ff;
   logic [StepBits-1:0] hstep_ff, vstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SizeBits'(512);
         height_ff <= SizeBits'(512);
         hstep_ff  <= StepBits'(65536);
         vstep_ff  <= StepBits'(65536);
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SOURCE_WIDTH:    width_ff  <= csr_data[SizeBits-1:0];
            CSR_SOURCE_HEIGHT:   height_ff <= csr_data[SizeBits-1:0];
            CSR_HORIZONTAL_STEP: hstep_ff  <= csr_data;
            CSR_VERTICAL_STEP:   vstep_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // saturated last index per axis
   logic [IndexBits:0] lastx, lasty;
   always_comb begin
      if (width_ff == '0) lastx = '0;
      else if (13'(width_ff) > 13'(MAX_SOURCE_WIDTH)) lastx = 13'(MAX_SOURCE_WIDTH - 1);
      else lastx = 13'(width_ff) - 13'd1;
      if (height_ff == '0) lasty = '0;
      else if (13'(height_ff) > 13'(MAX_SOURCE_HEIGHT)) lasty = 13'(MAX_SOURCE_HEIGHT - 1);
      else lasty = 13'(height_ff) - 13'd1;
   end

   st_type state_ff, state_in;
   logic signed [IndexBits+14:0] bx_ff, by_ff;   // base - 1 (may be negative)
   logic [15:0] fx_ff, fy_ff;
   logic [1:0] kx_ff, ky_ff;
   logic rd_pend_ff;
   logic [1:0] rd_kx_ff;
   logic signed [LineBits-1:0] line_ff [3];
   logic signed [AccBits-1:0]  acc_ff [3];

   // axis map: ((2i+1)*step + 65536) >> 1, 37-bit product
   logic [36:0] tx, ty, btx, bty;
   assign tx  = 37'({req_column, 1'b1}) * 37'(hstep_ff);
   assign ty  = 37'({req_row, 1'b1}) * 37'(vstep_ff);
   assign btx = (tx + 37'd65536) >> 1;
   assign bty = (ty + 37'd65536) >> 1;

   // weights
   logic wgo, wdx, wdy;
   logic signed [WFB+1:0] wx [4];
   logic signed [WFB+1:0] wy [4];
   assign wgo = (state_ff == S_MAP);

   bir_weights #(.WFB(WFB)) u_wx (
      .clock(clock), .reset(reset), .go(wgo), .frac(fx_ff), .done(wdx),
      .w0(wx[0]), .w1(wx[1]), .w2(wx[2]), .w3(wx[3])
   );
   bir_weights #(.WFB(WFB)) u_wy (
      .clock(clock), .reset(reset), .go(wgo), .frac(fy_ff), .done(wdy),
      .w0(wy[0]), .w1(wy[1]), .w2(wy[2]), .w3(wy[3])
   );

   // window coordinates, edge replicated
   logic signed [IndexBits+15:0] sxw, syw;
   logic [XBits-1:0] sx;
   logic [YBits-1:0] sy;
   assign sxw = 28'(bx_ff) + 28'(kx_ff);
   assign syw = 28'(by_ff) + 28'(ky_ff);
   always_comb begin
      if (sxw < 0) sx = '0;
      else if (sxw > 28'(lastx)) sx = lastx[XBits-1:0];
      else sx = sxw[XBits-1:0];
      if (syw < 0) sy = '0;
      else if (syw > 28'(lasty)) sy = lasty[YBits-1:0];
      else sy = syw[YBits-1:0];
   end

   // RAM access
   logic accept, store_ok, ram_we;
   logic [ABits-1:0] ram_addr;
   logic [PixelBits-1:0] ram_q;
   assign accept   = start && !busy;
   assign store_ok = (32'(req_column) < MAX_SOURCE_WIDTH)
                     && (32'(req_row) < MAX_SOURCE_HEIGHT);
   assign ram_we   = accept && (req_operation == OP_STORE) && store_ok;
   assign ram_addr = ram_we ? {req_row[YBits-1:0], req_column[XBits-1:0]} : {sy, sx};

   bir_ram #(.WIDTH(PixelBits), .DEPTH(Depth)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data({req_red_in, req_green_in, req_blue_in}), .rd_data(ram_q)
   );

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && req_operation == OP_COMPUTE) state_in = S_MAP;
         S_MAP:  state_in = S_WGT;
         S_WGT:  if (wdx && wdy) state_in = S_RD;
         S_RD:   if (kx_ff == 2'd3) state_in = S_ROW;
         S_ROW:  state_in = (ky_ff == 2'd3) ? S_FIN : S_RD;
         S_FIN:  state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == S_RD);
      end
   end

   function automatic logic [7:0] finish(input logic signed [AccBits-1:0] s);
      logic signed [AccBits-1:0] q;
      logic [Sh-1:0] rem;
      logic up;
      begin
         q   = s >>> Sh;
         rem = s[Sh-1:0];
         up  = rem[Sh-1] && ((rem[Sh-2:0] != '0) || q[0]);
         q   = q + AccBits'(up);
         if (q < 0) finish = 8'd0;
         else if (q > 255) finish = 8'd255;
         else finish = q[7:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      rd_kx_ff <= kx_ff;
      unique case (state_ff)
         S_IDLE: begin
            bx_ff <= 27'(btx[36:16]) - 27'sd2;
            by_ff <= 27'(bty[36:16]) - 27'sd2;
            fx_ff <= btx[15:0];
            fy_ff <= bty[15:0];
            kx_ff <= '0;
            ky_ff <= '0;
            for (int c = 0; c < 3; c++) acc_ff[c] <= '0;
         end
         S_RD: kx_ff <= kx_ff + 2'd1;
         S_ROW: ky_ff <= ky_ff + 2'd1;
         default: ;
      endcase
      // accumulate the word that arrives in the cycle after its read
      if (rd_pend_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (rd_kx_ff == 2'd0)
               line_ff[c] <= LineBits'($signed({1'b0, ram_q[16-8*c +: 8]}) * wx[0]);
            else
               line_ff[c] <= line_ff[c]
                  + LineBits'($signed({1'b0, ram_q[16-8*c +: 8]}) * wx[rd_kx_ff]);
         end
      end
      // fold the finished line: its last pixel lands in the S_ROW cycle, which advances
      // the row counter, so the fold in the next S_RD or in S_FIN uses the previous row's weight
      if (state_ff == S_FIN || (state_ff == S_RD && kx_ff == 2'd0 && ky_ff != 2'd0)) begin
         for (int c = 0; c < 3; c++)
            acc_ff[c] <= acc_ff[c] + AccBits'(line_ff[c]) * AccBits'(wy[ky_ff - 2'd1]);
      end
   end

   // the accumulator holds through S_OUT; round it on the way out
   assign done          = (state_ff == S_OUT);
   assign rsp_red_out   = finish(acc_ff[0]);
   assign rsp_green_out = finish(acc_ff[1]);
   assign rsp_blue_out  = finish(acc_ff[2]);

   // a compute word never yields a result before its sixteen reads
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff == S_FIN)) else $error("result without finish");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ram_we) else $error("RAM write during compute");
   a_row_after_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> $past(kx_ff) == 2'd3) else $error("short row");

endmodule
`default_nettype wire
